[rtl/gdvf_pkg.sv]
package gdvf_pkg;

  localparam int ALLELE_W = 8;
  localparam int DEPTH_W  = 16;
  localparam int CODE_W   = 3;
  localparam int BOUND_W  = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = BOUND_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MISSING_OK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANY_ALT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_FLOOR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CEILING = 2'd3;

  localparam logic [BOUND_W-1:0] BOUND_OFF = {BOUND_W{1'b1}};

  localparam logic [CODE_W-1:0] CODE_HOMREF        = 3'd1;
  localparam logic [CODE_W-1:0] CODE_HOMALT        = 3'd2;
  localparam logic [CODE_W-1:0] CODE_HET           = 3'd3;
  localparam logic [CODE_W-1:0] CODE_HET_HOMREF    = 3'd4;
  localparam logic [CODE_W-1:0] CODE_HOMALT_HET    = 3'd5;
  localparam logic [CODE_W-1:0] CODE_HOMREF_HOMALT = 3'd6;
  localparam logic [CODE_W-1:0] CODE_ANY           = 3'd7;

  typedef struct packed {
    logic               valid;
    logic               match;
    logic               depth_present;
    logic [DEPTH_W-1:0] depth;
    logic               last;
  } smp_t;

  function automatic logic gt_match(
    input logic [ALLELE_W-1:0] a,
    input logic [ALLELE_W-1:0] b,
    input logic                missing,
    input logic [CODE_W-1:0]   code,
    input logic                missing_ok,
    input logic                any_alt
  );
    logic homref;
    logic homalt;
    logic het;
    logic a_zero;
    logic b_zero;
    logic a_one;
    logic b_one;
    logic res;
    a_zero = (a == '0);
    b_zero = (b == '0);
    a_one  = (a == ALLELE_W'(1));
    b_one  = (b == ALLELE_W'(1));
    homref = a_zero && b_zero;
    if (any_alt) begin
      homalt = (a == b) && !a_zero;
      het    = (a != b) && (a_zero || b_zero);
    end else begin
      homalt = a_one && b_one;
      het    = (a_zero && b_one) || (a_one && b_zero);
    end
    unique case (code)
      CODE_HOMREF:        res = homref;
      CODE_HOMALT:        res = homalt;
      CODE_HET:           res = het;
      CODE_HET_HOMREF:    res = het || homref;
      CODE_HOMALT_HET:    res = homalt || het;
      CODE_HOMREF_HOMALT: res = homref || homalt;
      CODE_ANY:           res = 1'b1;
      default:            res = 1'b0;
    endcase
    if (missing) begin
      res = missing_ok;
    end
    return res;
  endfunction

endpackage

[rtl/gdvf_classify.sv]
module gdvf_classify
  import gdvf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ALLELE_W-1:0] in_allele_first,
  input  logic [ALLELE_W-1:0] in_allele_second,
  input  logic                in_call_missing,
  input  logic [DEPTH_W-1:0]  in_sample_depth,
  input  logic                in_depth_present,
  input  logic [CODE_W-1:0]   in_sample_code,
  input  logic                in_sample_last,
  input  logic                missing_ok,
  input  logic                any_alt,
  input  logic                s1_adv,
  output smp_t                smp
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [ALLELE_W-1:0] a_r;
  logic [ALLELE_W-1:0] b_r;
  logic                missing_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic                dpres_r;
  logic [CODE_W-1:0]   code_r;
  logic                last_r;
  logic                accept;

  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r       <= in_allele_first;
      b_r       <= in_allele_second;
      missing_r <= in_call_missing;
      depth_r   <= in_sample_depth;
      dpres_r   <= in_depth_present;
      code_r    <= in_sample_code;
      last_r    <= in_sample_last;
    end
  end

  assign smp.valid         = s1_valid_r;
  assign smp.match         = gt_match(a_r, b_r, missing_r, code_r, missing_ok, any_alt);
  assign smp.depth_present = dpres_r;
  assign smp.depth         = depth_r;
  assign smp.last          = last_r;

endmodule

[rtl/gdvf_accum.sv]
module gdvf_accum
  import gdvf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  smp_t               smp,
  input  logic [BOUND_W-1:0] depth_floor,
  input  logic [BOUND_W-1:0] depth_ceiling,
  output logic               s1_adv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_keep_variant,
  output logic               out_genotype_failed,
  output logic               out_depth_failed
);

  logic               fail_r, fail_nxt;
  logic [DEPTH_W-1:0] low_r, low_nxt;
  logic [DEPTH_W-1:0] high_r, high_nxt;
  logic               seen_r, seen_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               keep_r, gfail_r, dfail_r;
  logic               fail_upd, seen_upd;
  logic [DEPTH_W-1:0] low_upd, high_upd;
  logic               floor_on, ceil_on, dfail;

  // a non-last sample never needs the result register
  assign s1_adv = smp.valid && (!smp.last || !out_valid_r || !out_stall);

  always_comb begin
    fail_upd = fail_r || !smp.match;
    low_upd  = low_r;
    high_upd = high_r;
    seen_upd = seen_r;
    if (smp.depth_present) begin
      if (smp.depth < low_r) begin
        low_upd = smp.depth;
      end
      if (smp.depth > high_r) begin
        high_upd = smp.depth;
      end
      seen_upd = 1'b1;
    end
  end

  // sign bit clear means the bound is enabled
  assign floor_on = !depth_floor[BOUND_W-1];
  assign ceil_on  = !depth_ceiling[BOUND_W-1];
  assign dfail = seen_upd &&
                 ((floor_on && (low_upd < depth_floor[DEPTH_W-1:0])) ||
                  (ceil_on && (high_upd > depth_ceiling[DEPTH_W-1:0])));

  always_comb begin
    fail_nxt = fail_r;
    low_nxt  = low_r;
    high_nxt = high_r;
    seen_nxt = seen_r;
    if (s1_adv) begin
      if (smp.last) begin
        fail_nxt = 1'b0;
        low_nxt  = '1;
        high_nxt = '0;
        seen_nxt = 1'b0;
      end else begin
        fail_nxt = fail_upd;
        low_nxt  = low_upd;
        high_nxt = high_upd;
        seen_nxt = seen_upd;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && smp.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r      <= 1'b0;
      low_r       <= '1;
      high_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fail_r      <= fail_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && smp.last) begin
      keep_r  <= !fail_upd && !dfail;
      gfail_r <= fail_upd;
      dfail_r <= dfail;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_keep_variant    = keep_r;
  assign out_genotype_failed = gfail_r;
  assign out_depth_failed    = dfail_r;

endmodule

[rtl/genotype_depth_variant_filter_core.sv]
// Result path: a last-sample beat's result reaches the out_ ports through the input register,
// then the result register; a stalled result holds the beat in the input register.
// Throughput: one sample beat per cycle; the input register and the result
// register each hold one beat, so the input stalls only behind a stalled result.
// Reset: synchronous, active low; clears the per-variant accumulators, the
// valid flags and the configuration (missing calls fail, single-allele rules, no depth bounds).
module genotype_depth_variant_filter_core
  import gdvf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ALLELE_W-1:0]   in_allele_first,
  input  logic [ALLELE_W-1:0]   in_allele_second,
  input  logic                  in_call_missing,
  input  logic [DEPTH_W-1:0]    in_sample_depth,
  input  logic                  in_depth_present,
  input  logic [CODE_W-1:0]     in_sample_code,
  input  logic                  in_sample_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_keep_variant,
  output logic                  out_genotype_failed,
  output logic                  out_depth_failed,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic               missing_ok_r;
  logic               any_alt_r;
  logic [BOUND_W-1:0] depth_floor_r;
  logic [BOUND_W-1:0] depth_ceiling_r;
  logic               s1_adv;
  smp_t               smp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      missing_ok_r    <= 1'b0;
      any_alt_r       <= 1'b0;
      depth_floor_r   <= BOUND_OFF;
      depth_ceiling_r <= BOUND_OFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MISSING_OK:    missing_ok_r    <= cfg_wdata[0];
        CFG_ANY_ALT:       any_alt_r       <= cfg_wdata[0];
        CFG_DEPTH_FLOOR:   depth_floor_r   <= cfg_wdata[BOUND_W-1:0];
        CFG_DEPTH_CEILING: depth_ceiling_r <= cfg_wdata[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  gdvf_classify u_classify (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_allele_first  (in_allele_first),
    .in_allele_second (in_allele_second),
    .in_call_missing  (in_call_missing),
    .in_sample_depth  (in_sample_depth),
    .in_depth_present (in_depth_present),
    .in_sample_code   (in_sample_code),
    .in_sample_last   (in_sample_last),
    .missing_ok       (missing_ok_r),
    .any_alt          (any_alt_r),
    .s1_adv           (s1_adv),
    .smp              (smp)
  );

  gdvf_accum u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .smp                 (smp),
    .depth_floor         (depth_floor_r),
    .depth_ceiling       (depth_ceiling_r),
    .s1_adv              (s1_adv),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_keep_variant    (out_keep_variant),
    .out_genotype_failed (out_genotype_failed),
    .out_depth_failed    (out_depth_failed)
  );

endmodule

[rtl/gdvf_checker.sv]
module gdvf_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_keep_variant,
  input logic out_genotype_failed,
  input logic out_depth_failed
);

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_keep_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_keep_variant == !(out_genotype_failed || out_depth_failed)))
    else $error("keep flag disagrees with failure flags");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_keep_variant) && $stable(out_genotype_failed)
                               && $stable(out_depth_failed))
    else $error("stalled result beat changed");

endmodule

bind genotype_depth_variant_filter_core gdvf_checker u_gdvf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_keep_variant    (out_keep_variant),
  .out_genotype_failed (out_genotype_failed),
  .out_depth_failed    (out_depth_failed)
);
